@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL, included by rocauc_dp.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/rocauc_pkg.sv @@
// Widths, register map and controller/datapath interface types for the ROC AUC block.
// Depends on nothing; used by every module of the block.
package rocauc_pkg;

    localparam int SCORE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int MAX_ITEMS     = 1048576;

    // Counters must be able to hold MAX_ITEMS itself.
    localparam int CNT_W     = $clog2(MAX_ITEMS) + 1;
    localparam int SUM_W     = CNT_W + 1;
    localparam int PROD_W    = CNT_W + SUM_W;
    localparam int AREA_W    = 2 * CNT_W;
    localparam int DEN_W     = 2 * CNT_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int AUC_W     = FRACTION_BITS + 1;
    localparam int OUT_DATA_W = ((AUC_W + 7) / 8) * 8;
    localparam int DIV_CNT_W = $clog2(FRACTION_BITS);

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register word index within the configuration space.
    localparam logic [CFG_ADDR_W-3:0] REG_POSITIVE_TOTAL = '0;

    localparam logic [AUC_W-1:0] AUC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic load;
        logic mul_area;
        logic acc;
        logic count;
        logic mul_den;
        logic div_init;
        logic div_step;
        logic emit;
    } rocauc_cmd_t;

    typedef struct packed {
        logic close_needed;
        logic last;
        logic div_skip;
        logic div_last;
        logic out_free;
    } rocauc_status_t;

endpackage

@@ rtl/roc_auc_trapezoid_stream.sv @@
// Top level of the streaming ROC AUC block: stream ports, configuration register
// and the controller/datapath pair. Depends on rocauc_pkg, rocauc_ctrl, rocauc_dp.
//
//  Port group   Dir   tdata                         tuser          tlast
//  s_*          in    score [31:0]                  is_positive    last_item
//  m_*          out   auc_fraction [16:0]           degenerate     -
//  p*           cfg   reg 0 positive_total [20:0] at byte address 0
//
// A word with an unchanged score is loaded, checked and counted; one that closes a tie
// group also forms and accumulates its trapezoid area before it is counted. The last
// word adds the final point, the divisor product and a restoring divider that retires
// one quotient bit a cycle; the divide steps are skipped when the result saturates or
// is degenerate. A result still waiting in the output register holds the next result
// in its emit cycle, and the input with it. Reset clears all stream state and
// positive_total.
module roc_auc_trapezoid_stream
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rocauc_pkg::SCORE_BITS-1:0]     s_tdata,   // [31:0] score
    input  logic                                  s_tuser,   // [0] is_positive
    input  logic                                  s_tlast,   // last_item
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rocauc_pkg::OUT_DATA_W-1:0]     m_tdata,   // [16:0] auc_fraction, rest zero
    output logic                                  m_tuser,   // [0] degenerate
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rocauc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rocauc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rocauc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int CNT_W      = rocauc_pkg::CNT_W;
    localparam int CFG_DATA_W = rocauc_pkg::CFG_DATA_W;
    localparam int CFG_ADDR_W = rocauc_pkg::CFG_ADDR_W;

    logic [CNT_W-1:0]           positive_total_reg;
    logic                       reg_hit;
    rocauc_pkg::rocauc_cmd_t    cmd;
    rocauc_pkg::rocauc_status_t status;
    logic [rocauc_pkg::AUC_W-1:0] auc_fraction;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_ADDR_W-1:2] == rocauc_pkg::REG_POSITIVE_TOTAL);
    assign prdata  = reg_hit ? CFG_DATA_W'(positive_total_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            positive_total_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            positive_total_reg <= pwdata[CNT_W-1:0];
        end
    end

    rocauc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rocauc_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_score         (s_tdata),
        .in_is_positive   (s_tuser),
        .in_last_item     (s_tlast),
        .positive_total   (positive_total_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_auc_fraction (auc_fraction),
        .out_degenerate   (m_tuser)
    );

    assign m_tdata = rocauc_pkg::OUT_DATA_W'(auc_fraction);

endmodule

@@ rtl/rocauc_ctrl.sv @@
// Sequencer for the ROC AUC block: steps each word through compare, close, count,
// and the final divide. Depends on rocauc_pkg.
module rocauc_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  rocauc_pkg::rocauc_status_t status,
    output rocauc_pkg::rocauc_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_ACC1    = 4'd2;
    localparam logic [3:0] S_COUNT   = 4'd3;
    localparam logic [3:0] S_MUL2    = 4'd4;
    localparam logic [3:0] S_ACC2    = 4'd5;
    localparam logic [3:0] S_DEN     = 4'd6;
    localparam logic [3:0] S_DIVINIT = 4'd7;
    localparam logic [3:0] S_DIV     = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // A new score closes the previous tie group before this word counts.
                if (status.close_needed)
                begin
                    cmd.mul_area = 1'b1;
                    state_next   = S_ACC1;
                end
                else
                begin
                    cmd.count  = 1'b1;
                    state_next = status.last ? S_MUL2 : S_IDLE;
                end
            end
            S_ACC1:
            begin
                cmd.acc    = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = status.last ? S_MUL2 : S_IDLE;
            end
            S_MUL2:
            begin
                cmd.mul_area = 1'b1;
                state_next   = S_ACC2;
            end
            S_ACC2:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.mul_den = 1'b1;
                state_next  = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = status.div_skip ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/rocauc_dp.sv @@
// Datapath of the ROC AUC block: counters, shared multiplier, area accumulator,
// restoring divider and the output word register. Depends on rocauc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rocauc_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rocauc_pkg::rocauc_cmd_t                cmd,
    output rocauc_pkg::rocauc_status_t             status,
    input  logic [rocauc_pkg::SCORE_BITS-1:0]      in_score,
    input  logic                                   in_is_positive,
    input  logic                                   in_last_item,
    input  logic [rocauc_pkg::CNT_W-1:0]           positive_total,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [rocauc_pkg::AUC_W-1:0]           out_auc_fraction,
    output logic                                   out_degenerate
);

    localparam int CNT_W         = rocauc_pkg::CNT_W;
    localparam int SUM_W         = rocauc_pkg::SUM_W;
    localparam int PROD_W        = rocauc_pkg::PROD_W;
    localparam int AREA_W        = rocauc_pkg::AREA_W;
    localparam int DEN_W         = rocauc_pkg::DEN_W;
    localparam int REM_W         = rocauc_pkg::REM_W;
    localparam int FRACTION_BITS = rocauc_pkg::FRACTION_BITS;
    localparam int DIV_CNT_W     = rocauc_pkg::DIV_CNT_W;

    // Input word held while it is processed.
    logic [rocauc_pkg::SCORE_BITS-1:0] score_reg;
    logic                              positive_reg;
    logic                              last_reg;

    // Stream state.
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  neg_reg;
    logic [CNT_W-1:0]  items_reg;
    logic [CNT_W-1:0]  prior_pos_reg;
    logic [CNT_W-1:0]  prior_neg_reg;
    logic [rocauc_pkg::SCORE_BITS-1:0] prev_reg;
    logic              first_reg;
    logic [AREA_W-1:0] area_reg;

    // Arithmetic.
    logic [PROD_W-1:0]        mul_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [FRACTION_BITS-1:0] quot_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     degen_reg;
    logic                     sat_reg;

    // Output word.
    logic                            out_valid_reg;
    logic [rocauc_pkg::AUC_W-1:0]    auc_reg;
    logic                            out_degen_reg;

    logic                     count_ok;
    logic [CNT_W-1:0]         step;
    logic [SUM_W-1:0]         pos_sum;
    logic [CNT_W-1:0]         neg_total;
    logic [CNT_W-1:0]         mul_a;
    logic [SUM_W-1:0]         mul_b;
    logic [DEN_W-1:0]         den_value;
    logic                     area_ge_den;
    logic [REM_W-1:0]         rem_shift;
    logic                     rem_ge;
    logic [rocauc_pkg::AUC_W-1:0] auc_value;

    assign count_ok  = (items_reg < CNT_W'(rocauc_pkg::MAX_ITEMS));
    assign step      = neg_reg - prior_neg_reg;
    assign pos_sum   = SUM_W'(pos_reg) + SUM_W'(prior_pos_reg);
    assign neg_total = items_reg - positive_total;

    // One multiplier serves the trapezoid term and the divisor product P * N.
    assign mul_a = cmd.mul_den ? positive_total : step;
    assign mul_b = cmd.mul_den ? SUM_W'(neg_total) : pos_sum;

    assign den_value   = {mul_reg[DEN_W-2:0], 1'b0};
    assign area_ge_den = (DEN_W'(area_reg) >= den_value);

    assign rem_shift = {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge    = (rem_shift >= REM_W'(den_reg));

    always_comb
    begin
        priority if (degen_reg)
        begin
            auc_value = '0;
        end
        else if (sat_reg)
        begin
            auc_value = rocauc_pkg::AUC_ONE;
        end
        else
        begin
            auc_value = {1'b0, quot_reg};
        end
    end

    assign status.close_needed = count_ok && !first_reg && (score_reg != prev_reg);
    assign status.last         = last_reg;
    assign status.div_skip     = degen_reg || area_ge_den;
    assign status.div_last     = (div_cnt_reg == DIV_CNT_W'(FRACTION_BITS - 1));
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_auc_fraction = auc_reg;
    assign out_degenerate   = out_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            neg_reg       <= '0;
            items_reg     <= '0;
            prior_pos_reg <= '0;
            prior_neg_reg <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            area_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                area_reg      <= area_reg + mul_reg[AREA_W-1:0];
                prior_pos_reg <= pos_reg;
                prior_neg_reg <= neg_reg;
            end
            if (cmd.count && count_ok)
            begin
                if (positive_reg)
                begin
                    pos_reg <= pos_reg + CNT_W'(1);
                end
                else
                begin
                    neg_reg <= neg_reg + CNT_W'(1);
                end
                items_reg <= items_reg + CNT_W'(1);
                prev_reg  <= score_reg;
                first_reg <= 1'b0;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= '0;
                neg_reg       <= '0;
                items_reg     <= '0;
                prior_pos_reg <= '0;
                prior_neg_reg <= '0;
                prev_reg      <= '0;
                first_reg     <= 1'b1;
                area_reg      <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            score_reg    <= in_score;
            positive_reg <= in_is_positive;
            last_reg     <= in_last_item;
        end
        if (cmd.mul_area || cmd.mul_den)
        begin
            mul_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.mul_den)
        begin
            degen_reg <= (positive_total == '0) || (items_reg <= positive_total);
        end
        if (cmd.div_init)
        begin
            den_reg  <= den_value;
            rem_reg  <= REM_W'(area_reg);
            quot_reg <= '0;
            sat_reg  <= area_ge_den;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? (rem_shift - REM_W'(den_reg)) : rem_shift;
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], rem_ge};
        end
        if (cmd.emit)
        begin
            auc_reg       <= auc_value;
            out_degen_reg <= degen_reg;
        end
    end

    `ASSERT_RST(a_items_split, clk, rst_n, SUM_W'(items_reg) == SUM_W'(pos_reg) + SUM_W'(neg_reg), "item count differs from positives plus negatives")
    `ASSERT_RST(a_prior_order, clk, rst_n, prior_neg_reg <= neg_reg, "closed point lies beyond the negatives counted")
    `ASSERT_RST(a_rem_bound, clk, rst_n, cmd.div_step |-> rem_reg < REM_W'(den_reg), "divider remainder not below divisor")
    `ASSERT_RST(a_emit_clears, clk, rst_n, cmd.emit |=> (items_reg == '0) && first_reg, "stream state not cleared after result")

endmodule

@@ tb/sv/roc_auc_checker.sv @@
// Checker for the streaming ROC AUC block: follows the APB register and both stream
// channels, predicts the AUC word of every data set and compares. Depends on rocauc_pkg.
module roc_auc_checker
    import rocauc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [SCORE_BITS-1:0]   s_tdata,   // [31:0] score
    input  logic                    s_tuser,   // [0] is_positive
    input  logic                    s_tlast,   // last_item
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,   // [16:0] auc_fraction, rest zero
    input  logic                    m_tuser,   // [0] degenerate
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    input  logic [CFG_DATA_W-1:0]   prdata,
    input  logic                    pready,
    output int                      error_count,
    output int                      results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [AUC_W-1:0] auc;
        logic             degen;
    } auc_result_t;

    auc_result_t expected_auc_q[$];
    int mismatches = 0;
    int pending_n = 0;

    logic [CNT_W-1:0]      total_reg;
    logic [CNT_W-1:0]      pos_count;
    logic [CNT_W-1:0]      neg_count;
    logic [CNT_W-1:0]      group_pos;
    logic [CNT_W-1:0]      group_neg;
    logic [CNT_W-1:0]      item_count;
    logic [SCORE_BITS-1:0] last_score;
    logic                  awaiting_first;
    logic [AREA_W-1:0]     area_acc;

    assign error_count     = mismatches;
    assign results_pending = pending_n;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic clear_stream();
        pos_count      = '0;
        neg_count      = '0;
        group_pos      = '0;
        group_neg      = '0;
        item_count     = '0;
        last_score     = '0;
        awaiting_first = 1'b1;
        area_acc       = '0;
    endtask

    // One trapezoid: negative step times the sum of the positive counts at both ends.
    task automatic close_group();
        logic [CNT_W-1:0] step;
        step      = neg_count - group_neg;
        area_acc  = area_acc + step * (pos_count + group_pos);
        group_pos = pos_count;
        group_neg = neg_count;
    endtask

    function automatic auc_result_t auc_of(input logic [AREA_W-1:0] area,
                                           input logic [CNT_W-1:0] p,
                                           input logic [CNT_W-1:0] items);
        auc_result_t res;
        logic [63:0] den;
        logic [63:0] quo;
        res.auc   = '0;
        res.degen = 1'b1;
        if (p != 0 && items > p)
        begin
            den       = 64'(p) * 64'(items - p) * 2;
            res.degen = 1'b0;
            if (64'(area) >= den)
                res.auc = AUC_ONE;
            else
            begin
                quo     = (64'(area) << FRACTION_BITS) / den;
                res.auc = quo[AUC_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic predict_word(input logic [SCORE_BITS-1:0] score, input logic pos,
                                input logic last);
        // Words past the item limit are dropped, but a last word still closes the set.
        if (item_count < CNT_W'(MAX_ITEMS))
        begin
            if (!awaiting_first && score != last_score)
                close_group();
            if (pos)
                pos_count++;
            else
                neg_count++;
            item_count++;
            last_score     = score;
            awaiting_first = 1'b0;
        end
        if (last)
        begin
            close_group();
            expected_auc_q.push_back(auc_of(area_acc, total_reg, item_count));
            clear_stream();
        end
    endtask

    always @(posedge clk)
    begin : monitor
        auc_result_t want;
        if (!rst_n)
        begin
            total_reg = '0;
            clear_stream();
            expected_auc_q.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_POSITIVE_TOTAL)
            begin
                if (pwrite)
                    total_reg = pwdata[CNT_W-1:0];
                else if (prdata !== CFG_DATA_W'(total_reg))
                    flag_mismatch("positive_total readback", prdata, total_reg);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_auc_q.size() == 0)
                    flag_mismatch("result word with none expected", m_tdata, '0);
                else
                begin
                    want = expected_auc_q.pop_front();
                    if (m_tdata !== OUT_DATA_W'(want.auc))
                        flag_mismatch("auc_fraction", m_tdata, want.auc);
                    if (m_tuser !== want.degen)
                        flag_mismatch("degenerate", m_tuser, want.degen);
                end
            end
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tuser, s_tlast);
        end
        pending_n = expected_auc_q.size();
    end

endmodule

@@ tb/sv/roc_auc_trapezoid_stream_tb.sv @@
// Top of the ROC AUC testbench: clock, reset, APB setup of positive_total and
// item stimulus. Depends on rocauc_pkg, roc_auc_trapezoid_stream, roc_auc_checker.
module roc_auc_trapezoid_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rocauc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SET_PAUSE      = 40;
    localparam int TAIL_CYCLES    = 60;
    localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_ITEMS);

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SCORE_BITS-1:0] s_tdata;   // [31:0] score
    logic                  s_tuser;   // [0] is_positive
    logic                  s_tlast;   // last_item
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [16:0] auc_fraction, rest zero
    logic                  m_tuser;   // [0] degenerate
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int error_count;
    int results_pending;
    int src_idle_pct  = 8;
    int sink_idle_pct = 61;
    int words_sent    = 0;
    logic [CNT_W-1:0] programmed_total = '0;

    roc_auc_trapezoid_stream u_dut (.*);

    roc_auc_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_word(input logic [SCORE_BITS-1:0] score, input logic pos,
                             input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
            s_tlast  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= score;
        s_tuser  <= pos;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Setup and access phase of one transfer; the caller releases psel afterwards.
    task automatic apb_access(input logic write, input logic [CFG_DATA_W-1:0] wdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_POSITIVE_TOTAL, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // The register may only change once the block has finished the previous data set.
    task automatic program_total(input logic [CNT_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SET_PAUSE) @(negedge clk);
        apb_access(1'b1, CFG_DATA_W'(value));
        apb_access(1'b0, '0);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        programmed_total = value;
    endtask

    task automatic stream_random_set();
        int n;
        int k;
        int pos_left;
        int tie_pct;
        logic [CNT_W-1:0]      total;
        logic [SCORE_BITS-1:0] score;
        logic                  pos;
        n = ($urandom_range(15) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 1);
        // Reusing the current total lets sets follow each other without a register write.
        if ($urandom_range(1) == 1 && programmed_total <= n)
            k = int'(programmed_total);
        else
            k = $urandom_range(n, 0);
        case ($urandom_range(19))
            0: total = '0;
            1: total = TOTAL_MAX;
            2: total = CNT_W'(k + 1);
            3: total = (k > 0) ? CNT_W'(k - 1) : '0;
            default: total = CNT_W'(k);
        endcase
        if (total != programmed_total)
            program_total(total);
        case ($urandom_range(2))
            0: tie_pct = 0;
            1: tie_pct = 35;
            default: tie_pct = 80;
        endcase
        case ($urandom_range(7))
            0: score = '0;
            1: score = '1;
            default: score = $urandom;
        endcase
        pos_left = k;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0 && $urandom_range(99) >= tie_pct)
                score = $urandom;
            pos = ($urandom_range(n - i - 1) < pos_left);
            if (pos)
                pos_left--;
            send_word(score, pos, i == n - 1);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // No positives programmed: a single word gives a degenerate result.
        send_word('0, 1'b0, 1'b1);
        // The last word carries a new score, so two points close at once.
        program_total(1);
        send_word('1, 1'b1, 1'b0);
        send_word('0, 1'b0, 1'b1);
        send_word(32'd7, 1'b1, 1'b1);
        // One tie group holding everything gives exactly one half.
        program_total(2);
        send_word(32'd9, 1'b1, 1'b0);
        send_word(32'd9, 1'b0, 1'b0);
        send_word(32'd9, 1'b1, 1'b0);
        send_word(32'd9, 1'b0, 1'b1);
        // More positives than programmed: the divisor uses the programmed total, here giving one half.
        program_total(1);
        send_word(32'd40, 1'b1, 1'b0);
        send_word(32'd30, 1'b1, 1'b0);
        send_word(32'd30, 1'b0, 1'b0);
        send_word(32'd20, 1'b1, 1'b1);
        program_total(TOTAL_MAX);
        send_word(32'hAAAA_AAAA, 1'b1, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b1);
        program_total(3);
        send_word(32'd1, 1'b1, 1'b0);
        send_word(32'd2, 1'b1, 1'b0);
        send_word(32'd3, 1'b1, 1'b1);
        program_total(2);
        send_word(32'd100, 1'b1, 1'b0);
        send_word(32'd90, 1'b1, 1'b0);
        send_word(32'd80, 1'b0, 1'b0);
        send_word(32'd70, 1'b0, 1'b1);

        while (words_sent < 200)
            stream_random_set();
        src_idle_pct  = 61;
        sink_idle_pct = 8;
        while (words_sent < 380)
            stream_random_set();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (words_sent < 545)
            stream_random_set();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
